@@ rtl/pfba_pkg.sv @@
// shared constants, command codes and beat types for the page frame allocator
`default_nettype none
package pfba_pkg;

  localparam int NUM_FRAMES  = 4096;
  localparam int WORD_BITS   = 32;
  localparam int OFF_W       = $clog2(WORD_BITS);
  localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FRAME_W     = 12;
  localparam int PAGES_W     = 13;
  localparam int SCAN_W      = PAGES_W - OFF_W;
  localparam int INDEX_LIMIT = 4096;
  localparam int LIM_MAX     = (NUM_FRAMES < INDEX_LIMIT) ? NUM_FRAMES : INDEX_LIMIT;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [PAGES_W-1:0] USABLE_RESET = PAGES_W'(4096);

  typedef enum logic [0:0] {
    REG_USABLE_PAGES = 1'b0,
    REG_UNMAPPED     = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FRAME_W-1:0] page;
    logic               beyond;
  } op_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               success;
    logic               in_use;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/pfba_front.sv @@
// command intake: classifies each beat and holds it in a short queue for the back end
`default_nettype none
module pfba_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [1:0]                   command,
  input  logic [pfba_pkg::FRAME_W-1:0] page_number,
  output logic                         op_valid,
  input  logic                         op_ready,
  output pfba_pkg::op_t                op
);
  import pfba_pkg::*;

  op_t               queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  op_t               in_op;
  logic              push;
  logic              pop;

  always_comb begin
    in_op.cmd    = cmd_t'(command);
    in_op.page   = page_number;
    // frames past the map read as used and are never written
    in_op.beyond = (32'(page_number) >= 32'(NUM_FRAMES));
  end

  assign cmd_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign op_valid  = (count != '0);
  assign op        = queue[rd_ptr];
  assign push      = cmd_valid && cmd_ready;
  assign pop       = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/pfba_back.sv @@
// execution engine: used-bit map memory, first-fit word scan and result register
`default_nettype none
module pfba_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pfba_pkg::PAGES_W-1:0] usable_pages,
  input  logic                         op_valid,
  output logic                         op_ready,
  input  pfba_pkg::op_t                op,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output pfba_pkg::rsp_t               rsp
);
  import pfba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_t;

  state_t state, state_next;

  // map memory, one row of used bits per word; a row never written reads as all used
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rdv_q;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  op_t                  op_q;
  logic [SCAN_W-1:0]    chk_w, chk_w_next;
  logic [PAGES_W-1:0]   lim_q;
  logic                 lim_zero_q;
  logic [SCAN_W-1:0]    last_w_q;
  logic [PAGES_W-1:0]   lim;
  logic [PAGES_W-1:0]   lim_m1;

  logic [WORD_BITS-1:0] word;
  logic [OFF_W-1:0]     off;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] search_mask;
  logic [WORD_BITS-1:0] avail;
  logic                 hit;
  logic [OFF_W-1:0]     pos;
  logic                 out_free;
  logic                 load_rsp;
  rsp_t                 rsp_next;

  assign word     = rdv_q ? rd_q : '1;
  assign off      = op_q.page[OFF_W-1:0];
  assign cur_bit  = op_q.beyond ? 1'b1 : word[off];
  assign bit_mask = WORD_BITS'(1) << off;
  assign out_free = !rsp_valid || rsp_ready;
  assign lim      = (usable_pages > PAGES_W'(LIM_MAX)) ? PAGES_W'(LIM_MAX) : usable_pages;
  assign lim_m1   = lim - 1'b1;

  // only frames below the limit take part in the search
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      search_mask[b] = (chk_w < lim_q[PAGES_W-1:OFF_W]) ||
                       ((chk_w == lim_q[PAGES_W-1:OFF_W]) &&
                        (OFF_W'(b) < lim_q[OFF_W-1:0]));
    end
  end

  assign avail = ~word & search_mask;
  assign hit   = |avail;

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pos = OFF_W'(b);
      end
    end
  end

  always_comb begin
    state_next = state;
    op_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = WORD_AW'(op_q.page >> OFF_W);
    wr_data    = word;
    load_rsp   = 1'b0;
    rsp_next   = '0;
    chk_w_next = chk_w;
    unique case (state)
      ST_IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          rd_en = 1'b1;
          if (op.cmd == CMD_ALLOC) begin
            rd_addr    = '0;
            chk_w_next = '0;
            state_next = ST_SCAN;
          end else begin
            rd_addr    = WORD_AW'(op.page >> OFF_W);
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          load_rsp             = 1'b1;
          rsp_next.frame_index = op_q.page;
          rsp_next.success     = 1'b1;
          rsp_next.in_use      = cur_bit;
          if (!op_q.beyond && (op_q.cmd == CMD_FREE)) begin
            wr_en   = 1'b1;
            wr_data = word & ~bit_mask;
          end else if (!op_q.beyond && (op_q.cmd == CMD_RESERVE)) begin
            wr_en   = 1'b1;
            wr_data = word | bit_mask;
          end
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (out_free) begin
            wr_en                = 1'b1;
            wr_addr              = WORD_AW'(chk_w);
            wr_data              = word | (WORD_BITS'(1) << pos);
            load_rsp             = 1'b1;
            rsp_next.frame_index = FRAME_W'({chk_w, pos});
            rsp_next.success     = 1'b1;
            rsp_next.in_use      = 1'b0;
            state_next           = ST_IDLE;
          end
        end else if (lim_zero_q || (chk_w >= last_w_q)) begin
          if (out_free) begin
            load_rsp             = 1'b1;
            rsp_next.frame_index = '0;
            rsp_next.success     = 1'b0;
            rsp_next.in_use      = 1'b1;
            state_next           = ST_IDLE;
          end
        end else begin
          chk_w_next = chk_w + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = WORD_AW'(chk_w_next);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rdv_q <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
    chk_w <= chk_w_next;
    if (op_ready && op_valid) begin
      op_q       <= op;
      lim_q      <= lim;
      lim_zero_q <= (lim == '0);
      last_w_q   <= lim_m1[PAGES_W-1:OFF_W];
    end
  end

endmodule
`default_nettype wire

@@ rtl/page_frame_bitmap_allocator_unit.sv @@
// Page frame allocator top level: command channel, result channel and register port.
//
// Commands come in on cmd_valid/cmd_ready with command and page_number: allocate the
// lowest free frame, free a frame, reserve a frame, or query a frame. Each command
// gives exactly one result beat on rsp_valid/rsp_ready carrying frame_index, success
// and in_use (the frame's used bit before the command acted).
// A two-beat queue sits between intake and the engine, and the result has its own
// register, so a new command is taken while an earlier result still waits.
// Free, reserve and query read the frame's map word, then register the result. Allocate
// scans the used map one 32-bit word per cycle through the map memory's single read port
// until it finds a free bit below the usable_pages limit or reaches the last word.
// Commands are carried out one at a time, in order: the engine takes a new command
// only once the result of the previous one has been registered.
// A stalled result holds the engine; the queue then fills and cmd_ready drops.
// Reset marks every frame used (per-word valid bits, no clearing pass) and sets
// usable_pages to 4096. usable_pages sits at byte address 0 of the register port
// and should be written only while no command is in flight.
`default_nettype none
module page_frame_bitmap_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfba_pkg::APB_AW-1:0]  paddr,
  input  logic [pfba_pkg::APB_DW-1:0]  pwdata,
  output logic [pfba_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [1:0]                   command,
  input  logic [pfba_pkg::FRAME_W-1:0] page_number,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [pfba_pkg::FRAME_W-1:0] frame_index,
  output logic                         success,
  output logic                         in_use
);
  import pfba_pkg::*;

  logic [PAGES_W-1:0] usable_pages;
  reg_idx_t           reg_idx;
  logic               op_valid;
  logic               op_ready;
  op_t                op;
  rsp_t               rsp;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      usable_pages <= USABLE_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_USABLE_PAGES)) begin
      usable_pages <= pwdata[PAGES_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_USABLE_PAGES: prdata = APB_DW'(usable_pages);
      default:          prdata = '0;
    endcase
  end

  pfba_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .page_number (page_number),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op)
  );

  pfba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .usable_pages (usable_pages),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .op           (op),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp)
  );

  assign frame_index = rsp.frame_index;
  assign success     = rsp.success;
  assign in_use      = rsp.in_use;

endmodule
`default_nettype wire
